// File: rtl/core/assert_macros.svh
// Assertion macros used by the deframer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define EFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/efr_pkg.sv
// Types, codes and reset values shared by the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package efr_pkg;

  localparam int unsigned CfgDataWidth  = 32;
  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned LenWidth      = 16;
  localparam int unsigned TimeWidth     = 32;
  localparam int unsigned ByteWidth     = 8;
  localparam int unsigned StatusWidth   = 2;

  // Configuration register indexes
  typedef enum logic [CfgIndexWidth-1:0] {
    REG_IDLE_TIMEOUT        = 3'd0,
    REG_PAYLOAD_CAPACITY    = 3'd1,
    REG_END_CODE            = 3'd2,
    REG_ESCAPE_CODE         = 3'd3,
    REG_ESCAPED_END_CODE    = 3'd4,
    REG_ESCAPED_ESCAPE_CODE = 3'd5
  } reg_index_t;

  // Item operation codes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Frame status codes
  localparam logic [StatusWidth-1:0] STATUS_INCOMPLETE = 2'd0;
  localparam logic [StatusWidth-1:0] STATUS_COMPLETE   = 2'd1;
  localparam logic [StatusWidth-1:0] STATUS_DISCARDED  = 2'd2;

  // Register reset values
  localparam logic [TimeWidth-1:0] IDLE_TIMEOUT_RESET        = 32'd0;
  localparam logic [LenWidth-1:0]  PAYLOAD_CAPACITY_RESET    = 16'd256;
  localparam logic [ByteWidth-1:0] END_CODE_RESET            = 8'd192;
  localparam logic [ByteWidth-1:0] ESCAPE_CODE_RESET         = 8'd219;
  localparam logic [ByteWidth-1:0] ESCAPED_END_CODE_RESET    = 8'd220;
  localparam logic [ByteWidth-1:0] ESCAPED_ESCAPE_CODE_RESET = 8'd221;

  typedef struct packed {
    logic [TimeWidth-1:0] idle_timeout;
    logic [LenWidth-1:0]  payload_capacity;
    logic [ByteWidth-1:0] end_code;
    logic [ByteWidth-1:0] escape_code;
    logic [ByteWidth-1:0] escaped_end_code;
    logic [ByteWidth-1:0] escaped_escape_code;
  } cfg_t;

  typedef struct packed {
    logic                 op;
    logic [ByteWidth-1:0] rx_byte;
    logic [TimeWidth-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic                   payload_valid;
    logic [ByteWidth-1:0]   payload_byte;
    logic [LenWidth-1:0]    frame_length;
    logic                   timed_out;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/efr_if.sv
// Handshake channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none

interface efr_item_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [efr_pkg::ByteWidth-1:0]     rx_byte;
  logic [efr_pkg::TimeWidth-1:0]     now_ms;

  modport source (output valid, output op, output rx_byte, output now_ms, input ready);
  modport sink   (input valid, input op, input rx_byte, input now_ms, output ready);
endinterface

interface efr_result_if;
  logic                              valid;
  logic                              ready;
  logic [efr_pkg::StatusWidth-1:0]   status;
  logic                              payload_valid;
  logic [efr_pkg::ByteWidth-1:0]     payload_byte;
  logic [efr_pkg::LenWidth-1:0]      frame_length;
  logic                              timed_out;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output frame_length, output timed_out, input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input frame_length, input timed_out, output ready);
endinterface

`default_nettype wire

// File: rtl/core/efr_cfg_regs.sv
// Configuration register bank of the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none

module efr_cfg_regs (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 wr_en,
  input  wire logic [efr_pkg::CfgIndexWidth-1:0]    wr_index,
  input  wire logic [efr_pkg::CfgDataWidth-1:0]     wr_data,
  output efr_pkg::cfg_t                             cfg
);

  // Load defaults on reset, then take writes; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_timeout        <= efr_pkg::IDLE_TIMEOUT_RESET;
      cfg.payload_capacity    <= efr_pkg::PAYLOAD_CAPACITY_RESET;
      cfg.end_code            <= efr_pkg::END_CODE_RESET;
      cfg.escape_code         <= efr_pkg::ESCAPE_CODE_RESET;
      cfg.escaped_end_code    <= efr_pkg::ESCAPED_END_CODE_RESET;
      cfg.escaped_escape_code <= efr_pkg::ESCAPED_ESCAPE_CODE_RESET;
    end else if (wr_en) begin
      case (efr_pkg::reg_index_t'(wr_index))
        efr_pkg::REG_IDLE_TIMEOUT: begin
          cfg.idle_timeout <= wr_data[efr_pkg::TimeWidth-1:0];
        end
        efr_pkg::REG_PAYLOAD_CAPACITY: begin
          cfg.payload_capacity <= wr_data[efr_pkg::LenWidth-1:0];
        end
        efr_pkg::REG_END_CODE: begin
          cfg.end_code <= wr_data[efr_pkg::ByteWidth-1:0];
        end
        efr_pkg::REG_ESCAPE_CODE: begin
          cfg.escape_code <= wr_data[efr_pkg::ByteWidth-1:0];
        end
        efr_pkg::REG_ESCAPED_END_CODE: begin
          cfg.escaped_end_code <= wr_data[efr_pkg::ByteWidth-1:0];
        end
        efr_pkg::REG_ESCAPED_ESCAPE_CODE: begin
          cfg.escaped_escape_code <= wr_data[efr_pkg::ByteWidth-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/efr_deframer.sv
// Frame state and single-pass unescape logic of the escaped frame receiver.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module efr_deframer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire efr_pkg::item_t  item,
  input  wire efr_pkg::cfg_t   cfg,
  output efr_pkg::result_t     res
);

  logic [efr_pkg::LenWidth-1:0]  length_count, length_count_next;
  logic [efr_pkg::TimeWidth-1:0] last_byte_time, last_byte_time_next;
  logic                          escape_seen, escape_seen_next;
  logic                          discarding, discarding_next;

  logic [efr_pkg::TimeWidth-1:0] idle_span;
  logic                          active;
  logic                          push_req;
  logic [efr_pkg::ByteWidth-1:0] push_value;
  logic                          overflow;

  assign idle_span = item.now_ms - last_byte_time;
  assign active    = discarding || escape_seen || (length_count != '0);
  assign overflow  = (length_count >= cfg.payload_capacity);

  // Decode the item against the current frame state
  always_comb begin
    length_count_next   = length_count;
    last_byte_time_next = last_byte_time;
    escape_seen_next    = escape_seen;
    discarding_next     = discarding;
    push_req            = 1'b0;
    push_value          = item.rx_byte;
    res                 = '0;

    if (item.op == efr_pkg::OP_TICK) begin
      // Drop a partial frame once the line has been silent long enough
      if ((cfg.idle_timeout != '0) && active && (idle_span >= cfg.idle_timeout)) begin
        length_count_next   = '0;
        last_byte_time_next = '0;
        escape_seen_next    = 1'b0;
        discarding_next     = 1'b0;
        res.timed_out       = 1'b1;
      end
    end else begin
      last_byte_time_next = item.now_ms;
      if (discarding) begin
        // Skip everything up to the closing delimiter
        if (item.rx_byte == cfg.end_code) begin
          length_count_next   = '0;
          last_byte_time_next = '0;
          discarding_next     = 1'b0;
          res.status          = efr_pkg::STATUS_DISCARDED;
        end
      end else if (escape_seen) begin
        escape_seen_next = 1'b0;
        if (item.rx_byte == cfg.escaped_end_code) begin
          push_req   = 1'b1;
          push_value = cfg.end_code;
        end else if (item.rx_byte == cfg.escaped_escape_code) begin
          push_req   = 1'b1;
          push_value = cfg.escape_code;
        end else if (item.rx_byte == cfg.end_code) begin
          length_count_next   = '0;
          last_byte_time_next = '0;
          res.status          = efr_pkg::STATUS_DISCARDED;
        end else begin
          length_count_next = '0;
          discarding_next   = 1'b1;
        end
      end else if (item.rx_byte == cfg.end_code) begin
        // Close a non-empty frame; an empty one is ignored
        if (length_count != '0) begin
          length_count_next   = '0;
          last_byte_time_next = '0;
          res.status          = efr_pkg::STATUS_COMPLETE;
        end
      end else if (item.rx_byte == cfg.escape_code) begin
        escape_seen_next = 1'b1;
      end else begin
        push_req = 1'b1;
      end

      // Append one payload byte, or enter discard mode on overflow
      if (push_req) begin
        if (overflow) begin
          length_count_next = '0;
          escape_seen_next  = 1'b0;
          discarding_next   = 1'b1;
        end else begin
          length_count_next = length_count + 1'b1;
          res.payload_valid = 1'b1;
          res.payload_byte  = push_value;
        end
      end
    end

    // Completion reports the closing length, everything else the new one
    res.frame_length = (res.status == efr_pkg::STATUS_COMPLETE) ? length_count
                                                                : length_count_next;
  end

  // Advance frame state once per processed transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      length_count   <= '0;
      last_byte_time <= '0;
      escape_seen    <= 1'b0;
      discarding     <= 1'b0;
    end else if (step) begin
      length_count   <= length_count_next;
      last_byte_time <= last_byte_time_next;
      escape_seen    <= escape_seen_next;
      discarding     <= discarding_next;
    end
  end

  // Discard mode never carries a length or a pending escape
  `EFR_ASSERT_IMPL(a_discard_clean, clk, rst, discarding, (length_count == '0) && !escape_seen)
  // A finished or dropped frame leaves all frame state cleared
  `EFR_ASSERT_NEXT(a_close_clears, clk, rst, step && ((res.status != efr_pkg::STATUS_INCOMPLETE) || res.timed_out), (length_count == '0) && !escape_seen && !discarding && (last_byte_time == '0))
  // An emitted byte is always counted in the reported length
  `EFR_ASSERT_IMPL(a_byte_counted, clk, rst, res.payload_valid, (res.frame_length != '0) && (res.status == efr_pkg::STATUS_INCOMPLETE))

endmodule

`default_nettype wire

// File: rtl/core/escaped_frame_receiver.sv
// Each accepted item passes the input and then the result register; one result per item.
// Throughput: one item per cycle, set by the input register and the result register
//   that sit around the single-pass unescape logic; both hold while the result sink stalls.
// Reset (rst, synchronous, active high): clears frame state, both pipeline valids
//   and loads the configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module escaped_frame_receiver (
  input  wire logic                              clk,
  input  wire logic                              rst,
  efr_item_if.sink                               item,
  efr_result_if.source                           result,
  input  wire logic                              wr_en,
  input  wire logic [efr_pkg::CfgIndexWidth-1:0] wr_index,
  input  wire logic [efr_pkg::CfgDataWidth-1:0]  wr_data
);

  efr_pkg::cfg_t    cfg;
  efr_pkg::item_t   stage_item;
  logic             stage_valid;
  efr_pkg::result_t stage_res;
  efr_pkg::result_t out_res;
  logic             out_valid;
  logic             step;

  efr_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  efr_deframer u_deframer (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (stage_item),
    .cfg  (cfg),
    .res  (stage_res)
  );

  // Process the held item whenever the result register can take it
  assign step       = stage_valid && (!out_valid || result.ready);
  assign item.ready = !stage_valid || step;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
    if (item.valid && item.ready) begin
      stage_item.op      <= item.op;
      stage_item.rx_byte <= item.rx_byte;
      stage_item.now_ms  <= item.now_ms;
    end
  end

  // Result register; hold while the sink stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (step) begin
      out_res <= stage_res;
    end
  end

  assign result.valid         = out_valid;
  assign result.status        = out_res.status;
  assign result.payload_valid = out_res.payload_valid;
  assign result.payload_byte  = out_res.payload_byte;
  assign result.frame_length  = out_res.frame_length;
  assign result.timed_out     = out_res.timed_out;

endmodule

`default_nettype wire
